>>> rtl/rcw_pkg.sv
// ----------------------------------------------------------------------------
// rcw_pkg
// Shared types and codes for the replay counter window.
// ----------------------------------------------------------------------------
package rcw_pkg;

  localparam int unsigned CNT_W = 32;

  // verdict codes
  localparam logic [1:0] VERDICT_ACCEPT = 2'd0;
  localparam logic [1:0] VERDICT_DUP    = 2'd1;
  localparam logic [1:0] VERDICT_OLD    = 2'd2;
  localparam logic [1:0] VERDICT_NONE   = 2'd3;

  // one window entry as it travels around the ring
  typedef struct packed {
    logic             valid;
    logic [CNT_W-1:0] count;
  } entry_t;

endpackage

>>> rtl/rcw_if.sv
// ----------------------------------------------------------------------------
// rcw_in_if / rcw_out_if
// Valid/ready channels carrying a packet counter in and a verdict out.
// ----------------------------------------------------------------------------
interface rcw_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] packet_counter;

  modport source (output valid, output packet_counter, input ready);
  modport sink   (input valid, input packet_counter, output ready);
endinterface

interface rcw_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] verdict;

  modport source (output valid, output verdict, input ready);
  modport sink   (input valid, input verdict, output ready);
endinterface

>>> rtl/rcw_cell.sv
// ----------------------------------------------------------------------------
// rcw_cell
// One stage of the entry ring: holds an entry, takes its neighbor's on shift.
// ----------------------------------------------------------------------------
module rcw_cell
  import rcw_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   shift,
  input  entry_t d,
  output entry_t q
);

  logic             valid_r;
  logic [CNT_W-1:0] count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (shift) begin
      valid_r <= d.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      count_r <= d.count;
    end
  end

  assign q.valid = valid_r;
  assign q.count = count_r;

endmodule

>>> rtl/rcw_ctrl.sv
// ----------------------------------------------------------------------------
// rcw_ctrl
// Ring head: sequences the scan and update passes, checks and rewrites the
// entry leaving the last cell, and owns both channels.
// ----------------------------------------------------------------------------
module rcw_ctrl
  import rcw_pkg::*;
#(
  parameter int unsigned WINDOW   = 64,
  parameter int unsigned CAPACITY = 128
) (
  input  logic      clk,
  input  logic      rst_n,
  rcw_in_if.sink    in_if,
  rcw_out_if.source out_if,
  input  entry_t    head,
  output entry_t    feedback,
  output logic      shift
);

  localparam int unsigned CW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam logic [CNT_W:0] WIN_EXT = (CNT_W+1)'(WINDOW);
  localparam logic [CW-1:0]  LAST_IDX = CW'(CAPACITY - 1);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_UPDATE = 4'b0100,
    ST_EMIT   = 4'b1000
  } state_t;

  state_t           state_r, state_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [CNT_W-1:0] v_r, v_nxt;
  logic [CNT_W-1:0] hi_r, hi_nxt;
  logic [CNT_W-1:0] min_r, min_nxt;
  logic             old_r, old_nxt;
  logic             dup_r, dup_nxt;
  logic             room_r, room_nxt;
  logic             ins_r, ins_nxt;
  logic [1:0]       verdict_r, verdict_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [1:0]       out_verdict_r, out_verdict_nxt;

  logic             in_go;
  logic             emit_go;
  logic             last;
  logic             stale;
  logic             hit;
  logic [CNT_W:0]   head_age;
  logic [CNT_W:0]   in_age;

  assign in_if.ready    = (state_r == ST_IDLE);
  assign in_go          = in_if.valid && in_if.ready;
  assign out_if.valid   = out_valid_r;
  assign out_if.verdict = out_verdict_r;
  assign emit_go        = (state_r == ST_EMIT) && (!out_valid_r || out_if.ready);
  assign last           = (cnt_r == LAST_IDX);
  assign shift          = (state_r == ST_SCAN) || (state_r == ST_UPDATE);

  // head entry is outside the window of the new word once count + WINDOW <= v
  assign head_age = {1'b0, head.count} + WIN_EXT;
  assign stale    = head.valid && (head_age <= {1'b0, v_r});
  assign hit      = head.valid && (head.count == v_r);
  assign in_age   = {1'b0, in_if.packet_counter} + WIN_EXT;

  // update pass rewrites the head entry on its way back to cell 0
  always_comb begin
    feedback = head;
    if (state_r == ST_UPDATE) begin
      priority if (ins_r && room_r && (!head.valid || stale)) begin
        feedback.valid = 1'b1;
        feedback.count = v_r;
      end else if (ins_r && !room_r && head.valid && (head.count == min_r)) begin
        feedback.valid = 1'b1;
        feedback.count = v_r;
      end else if (stale) begin
        feedback.valid = 1'b0;
      end else begin
        feedback = head;
      end
    end
  end

  always_comb begin
    state_nxt       = state_r;
    cnt_nxt         = cnt_r;
    v_nxt           = v_r;
    hi_nxt          = hi_r;
    min_nxt         = min_r;
    old_nxt         = old_r;
    dup_nxt         = dup_r;
    room_nxt        = room_r;
    ins_nxt         = ins_r;
    verdict_nxt     = verdict_r;
    out_valid_nxt   = out_valid_r;
    out_verdict_nxt = out_verdict_r;

    if (out_valid_r && out_if.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_go) begin
          v_nxt     = in_if.packet_counter;
          old_nxt   = (in_age <= {1'b0, hi_r});
          dup_nxt   = 1'b0;
          room_nxt  = 1'b0;
          min_nxt   = '1;
          cnt_nxt   = '0;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (hit) begin
          dup_nxt = 1'b1;
        end
        if (!head.valid || stale) begin
          room_nxt = 1'b1;
        end
        if (head.valid && (head.count < min_r)) begin
          min_nxt = head.count;
        end
        cnt_nxt = cnt_r + 1'b1;
        if (last) begin
          cnt_nxt = '0;
          priority if (dup_r || hit) begin
            verdict_nxt = VERDICT_DUP;
            state_nxt   = ST_EMIT;
          end else if (old_r) begin
            verdict_nxt = VERDICT_OLD;
            state_nxt   = ST_EMIT;
          end else begin
            ins_nxt   = 1'b1;
            state_nxt = ST_UPDATE;
          end
        end
      end
      ST_UPDATE: begin
        if (ins_r && (room_r ? (!head.valid || stale)
                             : (head.valid && (head.count == min_r)))) begin
          ins_nxt = 1'b0;
        end
        cnt_nxt = cnt_r + 1'b1;
        if (last) begin
          cnt_nxt     = '0;
          verdict_nxt = VERDICT_ACCEPT;
          if (v_r > hi_r) begin
            hi_nxt = v_r;
          end
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (emit_go) begin
          out_valid_nxt   = 1'b1;
          out_verdict_nxt = verdict_r;
          state_nxt       = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      hi_r        <= '0;
      ins_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      hi_r        <= hi_nxt;
      ins_r       <= ins_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    v_r           <= v_nxt;
    min_r         <= min_nxt;
    old_r         <= old_nxt;
    dup_r         <= dup_nxt;
    room_r        <= room_nxt;
    verdict_r     <= verdict_nxt;
    out_verdict_r <= out_verdict_nxt;
  end

  // the new word always finds a slot during the update pass
  a_insert_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_UPDATE) && last |=> !ins_r)
    else $error("update pass ended without inserting the word");

  // only a fresh, non-duplicate word reaches the update pass
  a_update_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_UPDATE) |-> !dup_r && !old_r)
    else $error("rejected word entered update pass");

  // ring only moves while a pass is running, and passes start at position 0
  a_pass_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_go |=> (state_r == ST_SCAN) && (cnt_r == '0))
    else $error("scan pass did not start aligned");

  a_verdict_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_verdict_r != VERDICT_NONE))
    else $error("undefined verdict code");

  // highest accepted only moves on an accept
  a_hi_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_UPDATE) |=> $stable(hi_r))
    else $error("highest counter changed outside update");

endmodule

>>> rtl/replay_counter_window.sv
// ----------------------------------------------------------------------------
// replay_counter_window
// Anti-replay sliding window: a ring of entry cells rotated past one check
// and rewrite head.
//
//   channel | dir | handshake          | word
//   in_if   | in  | valid/ready        | packet_counter[31:0]
//   out_if  | out | valid/ready        | verdict[1:0]
//
// Each word makes one scan pass around the ring; a rejected word then
// goes to its verdict, an accepted one adds an update pass first. The
// single head unit sees one cell per cycle. Reset clears all valid bits
// and the highest counter at once. The verdict register lets the next word
// be accepted while a verdict waits; a word finishing while the previous
// verdict is still stalled waits in the head until it is taken.
// ----------------------------------------------------------------------------
module replay_counter_window
  import rcw_pkg::*;
#(
  parameter int unsigned WINDOW   = 64,
  parameter int unsigned CAPACITY = 128
) (
  input  logic      clk,
  input  logic      rst_n,
  rcw_in_if.sink    in_if,
  rcw_out_if.source out_if
);

  entry_t ring [CAPACITY];
  entry_t feedback;
  logic   shift;

  rcw_ctrl #(
    .WINDOW   (WINDOW),
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_if    (in_if),
    .out_if   (out_if),
    .head     (ring[CAPACITY-1]),
    .feedback (feedback),
    .shift    (shift)
  );

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    if (i == 0) begin : g_first
      rcw_cell u_cell (
        .clk   (clk),
        .rst_n (rst_n),
        .shift (shift),
        .d     (feedback),
        .q     (ring[i])
      );
    end else begin : g_next
      rcw_cell u_cell (
        .clk   (clk),
        .rst_n (rst_n),
        .shift (shift),
        .d     (ring[i-1]),
        .q     (ring[i])
      );
    end
  end

endmodule
